// ===== design/lti_pkg.sv =====
// Package for the lux table interpolator: breakpoint table, datapath widths
// and the stage payload structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lti_pkg;

    localparam int TABLE_POINTS = 9;
    localparam int CODE_BITS    = 12;   // breakpoint codes
    localparam int LUX_BITS     = 18;   // lux * 256
    localparam int W_BITS       = 11;   // widest segment is 1037 codes
    localparam int DX_BITS      = W_BITS;
    localparam int DY_BITS      = 17;   // largest lux step is 105584
    localparam int PROD_BITS    = DX_BITS + DY_BITS;
    localparam int Q_BITS       = DY_BITS;  // quotient stays below dy

    localparam logic [CODE_BITS-1:0] BP_CODE [TABLE_POINTS] = '{
        12'd1, 12'd4, 12'd14, 12'd52, 12'd189, 12'd662, 12'd1699, 12'd2366, 12'd2854
    };

    localparam logic [LUX_BITS-1:0] BP_LUX [TABLE_POINTS] = '{
        18'd259, 18'd799, 18'd2510, 18'd7022, 18'd17804, 18'd59564,
        18'd165148, 18'd249221, 18'd256000
    };

    // Segment picked for one sample; clamps and exact hits carry dx = 0.
    typedef struct packed {
        logic [DX_BITS-1:0]  dx;
        logic [DY_BITS-1:0]  dy;
        logic [W_BITS-1:0]   w;
        logic [LUX_BITS-1:0] y0;
    } seg_t;

    // Divider state: partial remainder and the shared dividend/quotient word.
    typedef struct packed {
        logic [W_BITS-1:0]   rem;
        logic [Q_BITS-1:0]   lq;
        logic [W_BITS-1:0]   w;
        logic [LUX_BITS-1:0] y0;
    } div_t;

endpackage

`default_nettype wire

// ===== design/lti_sample_if.sv =====
// Sample request channel: valid/ready handshake carrying one ADC sample.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface lti_sample_if #(
    parameter int SAMPLE_BITS = 12
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

// ===== design/lti_lux_if.sv =====
// Result channel: valid/ready handshake carrying one lux value.
// Depends on lti_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lti_lux_if ();
    logic                         valid;
    logic                         ready;
    logic [lti_pkg::LUX_BITS-1:0] lux_q8;

    modport source (output valid, output lux_q8, input ready);
    modport sink   (input valid, input lux_q8, output ready);
endinterface

`default_nettype wire

// ===== design/lux_table_interpolator.sv =====
// Top level: ADC sample to lux through a segment stage, a multiplier stage,
// a pipelined divider and an output adder. Depends on lti_pkg, the two
// channel interfaces, lti_segment, lti_mult and lti_div_stage.
//
//   channel   role    payload               width
//   sample    sink    adc_sample            SAMPLE_BITS
//   lux       source  lux_q8                18
//
// One request enters per cycle while the output is not stalled; the path is
// registered segment, multiply, 17 divider stages (one quotient bit each), output add.
// Reset clears the stage valid bits only; the data registers are not reset.
// Each stage carries its own valid bit and loads whenever it is empty or its
// successor takes its content, so a stalled output fills the pipe from the
// back and bubbles close up; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module lux_table_interpolator #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lti_sample_if.sink  sample,
    lti_lux_if.source   lux
);

    localparam int NDIV = lti_pkg::Q_BITS;

    logic                   seg_valid;
    logic                   seg_ready;
    lti_pkg::seg_t          seg;
    logic                   dv_valid [NDIV+1];
    logic                   dv_ready [NDIV+1];
    lti_pkg::div_t          dv       [NDIV+1];
    logic                   out_valid_reg;
    logic [lti_pkg::LUX_BITS-1:0] lux_reg;
    logic [lti_pkg::LUX_BITS-1:0] lux_next;
    logic                   out_in_ready;

    lti_segment #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_segment (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample.valid),
        .in_ready   (sample.ready),
        .adc_sample (sample.adc_sample),
        .out_valid  (seg_valid),
        .out_ready  (seg_ready),
        .seg        (seg)
    );

    lti_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .seg       (seg),
        .out_valid (dv_valid[0]),
        .out_ready (dv_ready[0]),
        .div       (dv[0])
    );

    for (genvar i = 0; i < NDIV; i++)
    begin : g_div
        lti_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[i]),
            .in_ready  (dv_ready[i]),
            .div_in    (dv[i]),
            .out_valid (dv_valid[i+1]),
            .out_ready (dv_ready[i+1]),
            .div_out   (dv[i+1])
        );
    end

    // output register: y0 plus quotient, never above the segment's upper entry
    assign out_in_ready   = !out_valid_reg || lux.ready;
    assign dv_ready[NDIV] = out_in_ready;
    assign lux_next       = dv[NDIV].y0 + lti_pkg::LUX_BITS'(dv[NDIV].lq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_in_ready)
        begin
            out_valid_reg <= dv_valid[NDIV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_in_ready && dv_valid[NDIV])
        begin
            lux_reg <= lux_next;
        end
    end

    assign lux.valid  = out_valid_reg;
    assign lux.lux_q8 = lux_reg;

endmodule

`default_nettype wire

// ===== design/lti_segment.sv =====
// First stage: locates the sample's segment and registers dx, dy, width, y0.
// Depends on lti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lti_segment #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] adc_sample,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output lti_pkg::seg_t               seg
);

    localparam int XW = (SAMPLE_BITS > lti_pkg::CODE_BITS) ? SAMPLE_BITS : lti_pkg::CODE_BITS;
    localparam int LAST = lti_pkg::TABLE_POINTS - 1;

    logic [XW-1:0]  x;
    logic           found;
    logic           valid_reg;
    lti_pkg::seg_t  seg_reg;
    lti_pkg::seg_t  seg_next;

    assign x        = XW'(adc_sample);
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        seg_next.dx = '0;
        seg_next.dy = '0;
        seg_next.w  = lti_pkg::W_BITS'(1);
        seg_next.y0 = lti_pkg::BP_LUX[LAST];
        found       = 1'b0;
        if (x <= XW'(lti_pkg::BP_CODE[0]))
        begin
            seg_next.y0 = lti_pkg::BP_LUX[0];
        end
        else if (x >= XW'(lti_pkg::BP_CODE[LAST]))
        begin
            seg_next.y0 = lti_pkg::BP_LUX[LAST];
        end
        else
        begin
            for (int k = 1; k < lti_pkg::TABLE_POINTS; k++)
            begin
                if (!found && x <= XW'(lti_pkg::BP_CODE[k]))
                begin
                    found = 1'b1;
                    // exact hit or degenerate segment: upper entry, no division
                    if (x == XW'(lti_pkg::BP_CODE[k]) ||
                        lti_pkg::BP_CODE[k] == lti_pkg::BP_CODE[k-1])
                    begin
                        seg_next.y0 = lti_pkg::BP_LUX[k];
                    end
                    else
                    begin
                        seg_next.dx = lti_pkg::DX_BITS'(x - XW'(lti_pkg::BP_CODE[k-1]));
                        seg_next.dy = lti_pkg::DY_BITS'(lti_pkg::BP_LUX[k] -
                                                        lti_pkg::BP_LUX[k-1]);
                        seg_next.w  = lti_pkg::W_BITS'(lti_pkg::BP_CODE[k] -
                                                       lti_pkg::BP_CODE[k-1]);
                        seg_next.y0 = lti_pkg::BP_LUX[k-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            seg_reg <= seg_next;
        end
    end

    assign out_valid = valid_reg;
    assign seg       = seg_reg;

endmodule

`default_nettype wire

// ===== design/lti_mult.sv =====
// Second stage: registered dx * dy product, split into the divider's start state.
// Depends on lti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lti_mult (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire lti_pkg::seg_t seg,
    output logic         out_valid,
    input  wire logic    out_ready,
    output lti_pkg::div_t div
);

    logic [lti_pkg::PROD_BITS-1:0] prod;
    logic                          valid_reg;
    lti_pkg::div_t                 div_reg;
    lti_pkg::div_t                 div_next;

    assign in_ready = !valid_reg || out_ready;
    assign prod     = lti_pkg::PROD_BITS'(seg.dx) * lti_pkg::PROD_BITS'(seg.dy);

    // prod < w * 2^Q_BITS, so the top bits already sit below the divisor
    always_comb
    begin
        div_next.rem = prod[lti_pkg::PROD_BITS-1:lti_pkg::Q_BITS];
        div_next.lq  = prod[lti_pkg::Q_BITS-1:0];
        div_next.w   = seg.w;
        div_next.y0  = seg.y0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign div       = div_reg;

endmodule

`default_nettype wire

// ===== design/lti_div_stage.sv =====
// One restoring-division step: retires one quotient bit per register stage.
// Depends on lti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lti_div_stage (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire lti_pkg::div_t div_in,
    output logic          out_valid,
    input  wire logic     out_ready,
    output lti_pkg::div_t div_out
);

    logic [lti_pkg::W_BITS:0] trial;
    logic [lti_pkg::W_BITS:0] diff;
    logic                     ge;
    logic                     valid_reg;
    lti_pkg::div_t            div_reg;
    lti_pkg::div_t            div_next;

    assign in_ready = !valid_reg || out_ready;
    assign trial    = {div_in.rem, div_in.lq[lti_pkg::Q_BITS-1]};
    assign diff     = trial - {1'b0, div_in.w};
    assign ge       = trial >= {1'b0, div_in.w};

    always_comb
    begin
        div_next.rem = ge ? diff[lti_pkg::W_BITS-1:0] : trial[lti_pkg::W_BITS-1:0];
        div_next.lq  = {div_in.lq[lti_pkg::Q_BITS-2:0], ge};
        div_next.w   = div_in.w;
        div_next.y0  = div_in.y0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = valid_reg;
    assign div_out   = div_reg;

endmodule

`default_nettype wire
